[hdl/dlpos_pkg.sv]
// Shared types and codes for the decimal-list ordered set.
package dlpos_pkg;

  localparam int VAL_W = 64;

  // Command codes
  localparam logic [2:0] CMD_TEXT   = 3'd0;
  localparam logic [2:0] CMD_INSERT = 3'd1;
  localparam logic [2:0] CMD_REMOVE = 3'd2;
  localparam logic [2:0] CMD_TEST   = 3'd3;
  localparam logic [2:0] CMD_POP    = 3'd4;
  localparam logic [2:0] CMD_CLEAR  = 3'd5;

  // Result status codes
  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_DUP     = 3'd1;
  localparam logic [2:0] ST_ABSENT  = 3'd2;
  localparam logic [2:0] ST_BADCHAR = 3'd3;
  localparam logic [2:0] ST_FULL    = 3'd4;

  // Characters the parser knows
  localparam logic [7:0] CHAR_NUL   = 8'h00;
  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_CR    = 8'h0d;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_COMMA = 8'h2c;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;

  // Operation broadcast to every cell of the chain
  localparam logic [2:0] OP_NONE   = 3'd0;
  localparam logic [2:0] OP_INSERT = 3'd1;
  localparam logic [2:0] OP_REMOVE = 3'd2;
  localparam logic [2:0] OP_POP    = 3'd3;
  localparam logic [2:0] OP_CLEAR  = 3'd4;

  typedef struct packed {
    logic [2:0]       op;
    logic [VAL_W-1:0] key;
  } cell_op_t;

  // Parser view of the current text beat
  typedef struct packed {
    logic       ins_req;
    logic [2:0] status;
    logic       string_end;
  } parse_res_t;

endpackage

[hdl/decimal_list_parser_ordered_set.sv]
// Top level: ordered set in a sorted cell chain, fed by commands and a list parser.
//
//   channel | handshake          | payload
//   --------+--------------------+-----------------------------------------------
//   in      | in_valid/in_ready  | command, value, text_byte
//   out     | out_valid/out_ready| status, string_end, smallest, smallest_valid,
//           |                    | count
//
// For every beat, the chain of cells compares the key with all
// held values in parallel and shifts at the accepting edge; the result is
// shown the next cycle. A new beat is taken in the cycle its result leaves,
// so the rate is one beat per cycle while out_ready stays high. When the
// result is stalled, in_ready drops. Reset empties the set and the parser.
module decimal_list_parser_ordered_set #(
  parameter int CAPACITY = 32,
  parameter int CNT_W    = $clog2(CAPACITY + 1)
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [2:0]                  command,
  input  logic signed [63:0]          value,
  input  logic [7:0]                  text_byte,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [2:0]                  status,
  output logic                        string_end,
  output logic signed [63:0]          smallest,
  output logic                        smallest_valid,
  output logic [CNT_W-1:0]            count
);
  import dlpos_pkg::*;

  logic                  in_fire;
  logic [VAL_W-1:0]      acc;
  parse_res_t            pres;
  logic [VAL_W-1:0]      key;
  logic                  found;
  logic                  full;
  logic [2:0]            ins_st;
  cell_op_t              op;
  logic [2:0]            status_next;
  logic [CNT_W-1:0]      count_next;

  logic [VAL_W-1:0]      cval [CAPACITY];
  logic [CAPACITY-1:0]   cvalid;
  logic [CAPACITY-1:0]   clt;
  logic [CAPACITY-1:0]   ceq;

  logic                  res_pop;
  logic                  pop_ok;
  logic [VAL_W-1:0]      pop_val;

  assign in_ready = !out_valid || out_ready;
  assign in_fire  = in_valid && in_ready;

  dlpos_parser u_parser (
    .clk        (clk),
    .rst        (rst),
    .take       (in_fire && command == CMD_TEXT),
    .text_byte  (text_byte),
    .ins_status (ins_st),
    .acc        (acc),
    .res        (pres)
  );

  // Membership and room checks on the selected key
  assign key    = (command == CMD_TEXT) ? acc : value;
  assign found  = |ceq;
  assign full   = (count == CNT_W'(CAPACITY));
  assign ins_st = found ? ST_DUP : (full ? ST_FULL : ST_OK);

  // Decode the beat into one chain operation
  always_comb begin
    op.key      = key;
    op.op       = OP_NONE;
    status_next = ST_OK;
    count_next  = count;
    case (command)
      CMD_TEXT: begin
        status_next = pres.status;
        if (pres.ins_req && ins_st == ST_OK) begin
          op.op      = OP_INSERT;
          count_next = count + 1'b1;
        end
      end
      CMD_INSERT: begin
        status_next = ins_st;
        if (ins_st == ST_OK) begin
          op.op      = OP_INSERT;
          count_next = count + 1'b1;
        end
      end
      CMD_REMOVE: begin
        status_next = found ? ST_OK : ST_ABSENT;
        if (found) begin
          op.op      = OP_REMOVE;
          count_next = count - 1'b1;
        end
      end
      CMD_TEST: status_next = found ? ST_OK : ST_ABSENT;
      CMD_POP: begin
        status_next = cvalid[0] ? ST_OK : ST_ABSENT;
        if (cvalid[0]) begin
          op.op      = OP_POP;
          count_next = count - 1'b1;
        end
      end
      CMD_CLEAR: begin
        op.op      = OP_CLEAR;
        count_next = '0;
      end
      default: ;
    endcase
    if (!in_fire) op.op = OP_NONE;
  end

  // Sorted chain, smallest value in cell 0
  genvar i;
  generate
    for (i = 0; i < CAPACITY; i++) begin : g_cell
      logic [VAL_W-1:0] lval;
      logic             lvalid;
      logic             llt;
      logic [VAL_W-1:0] rval;
      logic             rvalid;
      if (i == 0) begin : g_first
        assign lval   = '0;
        assign lvalid = 1'b1;
        assign llt    = 1'b0;
      end else begin : g_mid
        assign lval   = cval[i-1];
        assign lvalid = cvalid[i-1];
        assign llt    = clt[i-1];
      end
      if (i == CAPACITY - 1) begin : g_last
        assign rval   = '0;
        assign rvalid = 1'b0;
      end else begin : g_inner
        assign rval   = cval[i+1];
        assign rvalid = cvalid[i+1];
      end
      dlpos_cell u_cell (
        .clk         (clk),
        .rst         (rst),
        .op          (op),
        .left_val    (lval),
        .left_valid  (lvalid),
        .left_lt     (llt),
        .right_val   (rval),
        .right_valid (rvalid),
        .val         (cval[i]),
        .valid       (cvalid[i]),
        .lt          (clt[i]),
        .eq          (ceq[i])
      );
    end
  endgenerate

  // Count and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (in_fire) begin
        count     <= count_next;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
    if (in_fire) begin
      status     <= status_next;
      string_end <= (command == CMD_TEXT) && pres.string_end;
      res_pop    <= (command == CMD_POP);
      pop_ok     <= cvalid[0];
      pop_val    <= cval[0];
    end
  end

  // Cell 0 moves only on accepted beats; post-step minimum, or popped value on a pop
  always_comb begin
    if (res_pop) begin
      smallest       = pop_ok ? pop_val : '0;
      smallest_valid = pop_ok;
    end else begin
      smallest       = cvalid[0] ? cval[0] : '0;
      smallest_valid = cvalid[0];
    end
  end

endmodule

[hdl/dlpos_cell.sv]
// One slot of the sorted chain: holds a value, shifts with its neighbors.
module dlpos_cell (
  input  logic                       clk,
  input  logic                       rst,
  input  dlpos_pkg::cell_op_t        op,
  input  logic [dlpos_pkg::VAL_W-1:0] left_val,
  input  logic                       left_valid,
  input  logic                       left_lt,
  input  logic [dlpos_pkg::VAL_W-1:0] right_val,
  input  logic                       right_valid,
  output logic [dlpos_pkg::VAL_W-1:0] val,
  output logic                       valid,
  output logic                       lt,
  output logic                       eq
);
  import dlpos_pkg::*;

  logic                    le;
  logic [VAL_W-1:0]        val_next;
  logic                    valid_next;

  // Key compares against the held value
  assign lt = valid && ($signed(op.key) < $signed(val));
  assign eq = valid && (op.key == val);
  // Held value at or above the key: this cell and everything right of it close the gap
  assign le = lt || eq;

  // Shift rules: insert moves larger values right, removal pulls from the right
  always_comb begin
    val_next   = val;
    valid_next = valid;
    case (op.op)
      OP_INSERT: begin
        if (!valid || lt) begin
          if (left_lt) begin
            val_next   = left_val;
            valid_next = left_valid;
          end else if (left_valid) begin
            val_next   = op.key;
            valid_next = 1'b1;
          end
        end
      end
      OP_REMOVE: begin
        if (le) begin
          val_next   = right_val;
          valid_next = right_valid;
        end
      end
      OP_POP: begin
        val_next   = right_val;
        valid_next = right_valid;
      end
      OP_CLEAR: valid_next = 1'b0;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    val <= val_next;
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= valid_next;
    end
  end

endmodule

[hdl/dlpos_parser.sv]
// Decimal list parser: accumulates digits, flags separators, keeps string status.
module dlpos_parser (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        take,
  input  logic [7:0]                  text_byte,
  input  logic [2:0]                  ins_status,
  output logic [dlpos_pkg::VAL_W-1:0] acc,
  output dlpos_pkg::parse_res_t       res
);
  import dlpos_pkg::*;

  logic             started;
  logic             skip;
  logic [2:0]       str_status;
  logic [VAL_W-1:0] acc_next;
  logic             started_next;
  logic             skip_next;
  logic [2:0]       str_status_next;
  logic             is_digit;
  logic             is_sep;
  logic             is_end;
  logic [3:0]       digit;
  logic             ins_req;
  logic [2:0]       beat_status;
  logic             beat_end;

  assign is_end   = (text_byte == CHAR_NUL);
  assign is_digit = (text_byte >= CHAR_ZERO) && (text_byte <= CHAR_NINE);
  assign is_sep   = (text_byte == CHAR_COMMA) || (text_byte == CHAR_SPACE) ||
                    ((text_byte >= CHAR_TAB) && (text_byte <= CHAR_CR));
  assign digit    = text_byte[3:0];

  // A pending number is inserted on a separator or at end of string
  assign ins_req = !skip && started && (is_end || is_sep);

  assign res = '{ins_req: ins_req, status: beat_status, string_end: beat_end};

  always_comb begin
    acc_next        = acc;
    started_next    = started;
    skip_next       = skip;
    str_status_next = str_status;
    beat_status     = ST_OK;
    beat_end        = 1'b0;
    if (is_end) begin
      beat_end        = 1'b1;
      beat_status     = (ins_req && str_status == ST_OK) ? ins_status : str_status;
      acc_next        = '0;
      started_next    = 1'b0;
      skip_next       = 1'b0;
      str_status_next = ST_OK;
    end else if (skip) begin
      beat_status = ST_BADCHAR;
    end else if (is_digit) begin
      acc_next     = (acc << 3) + (acc << 1) + {{(VAL_W-4){1'b0}}, digit};
      started_next = 1'b1;
    end else if (is_sep) begin
      if (ins_req) begin
        beat_status = ins_status;
        if (str_status == ST_OK) str_status_next = ins_status;
      end
      acc_next     = '0;
      started_next = 1'b0;
    end else begin
      beat_status  = ST_BADCHAR;
      if (str_status == ST_OK) str_status_next = ST_BADCHAR;
      skip_next    = 1'b1;
      acc_next     = '0;
      started_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc        <= '0;
      started    <= 1'b0;
      skip       <= 1'b0;
      str_status <= ST_OK;
    end else if (take) begin
      acc        <= acc_next;
      started    <= started_next;
      skip       <= skip_next;
      str_status <= str_status_next;
    end
  end

endmodule

[hdl/dlpos_checker.sv]
// Port-level checks for the decimal-list ordered set, bound to the top level.
module dlpos_checker #(
  parameter int CAPACITY = 32,
  parameter int CNT_W    = $clog2(CAPACITY + 1)
) (
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_ready,
  input logic [2:0]          command,
  input logic                out_valid,
  input logic                out_ready,
  input logic [2:0]          status,
  input logic                string_end,
  input logic signed [63:0]  smallest,
  input logic                smallest_valid,
  input logic [CNT_W-1:0]    count
);

  // A stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(smallest) &&
      $stable(count) && $stable(string_end))
    else $error("result beat changed while stalled");

  a_cap: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(CAPACITY))
    else $error("count above capacity");

  // No real minimum is only reported for an empty set
  a_min_empty: assert property (@(posedge clk) disable iff (rst)
    out_valid && !smallest_valid |-> count == '0)
    else $error("missing minimum with values held");

  a_clear: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && command == dlpos_pkg::CMD_CLEAR |=>
      out_valid && count == '0 && status == dlpos_pkg::ST_OK && !smallest_valid)
    else $error("clear did not empty the set");

  a_end_text: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && command != dlpos_pkg::CMD_TEXT |=> !string_end)
    else $error("string end on a set command");

endmodule

bind decimal_list_parser_ordered_set dlpos_checker #(.CAPACITY(CAPACITY)) u_dlpos_checker (.*);
